@@ design/dgk_pkg.sv @@
package dgk_pkg;

  // Stage numbers: a value named after a stage is held in that stage's registers.
  localparam int unsigned DIST_W  = 32;                // root bits of the distance square root
  localparam int unsigned NORM_W  = 22;                // root bits of the norm square roots
  localparam int unsigned INV_W   = 48;                // quotient bits of the cube divisions
  localparam int unsigned Q1_W    = 42;                // quotient bits of the first cosine division
  localparam int unsigned Q2_W    = 32;                // quotient bits of the second cosine division

  localparam int unsigned ST_SUB  = 1;                 // saturated displacement
  localparam int unsigned ST_SQ   = 2;                 // squares and magnitudes
  localparam int unsigned ST_SUM  = 3;                 // sum of squares, normalizing shifts
  localparam int unsigned ST_D    = ST_SUM + DIST_W;   // distance ready
  localparam int unsigned ST_D2   = ST_D + 1;          // distance squared
  localparam int unsigned ST_PP   = ST_D + 2;          // cube partial products
  localparam int unsigned ST_C    = ST_D + 3;          // distance cubed
  localparam int unsigned ST_INV  = ST_C + INV_W;      // 1/r^3 quotient ready
  localparam int unsigned ST_NRM  = 4;                 // normalized vectors
  localparam int unsigned ST_PRD  = 5;                 // component products
  localparam int unsigned ST_DOT  = 6;                 // dot product and squared norms
  localparam int unsigned ST_NRT  = ST_DOT + NORM_W;   // norms ready
  localparam int unsigned ST_Q1   = ST_NRT + Q1_W;     // first cosine quotient ready
  localparam int unsigned ST_Q2   = ST_Q1 + Q2_W;      // second cosine quotient ready
  localparam int unsigned ST_COS  = ST_Q2 + 1;         // signed, clamped cosine
  localparam int unsigned ST_CSQ  = ST_COS + 1;        // cosine squared
  localparam int unsigned ST_T    = ST_CSQ + 1;        // angular term 3c^2-1
  localparam int unsigned ST_N3   = ST_T + 1;          // overflow check of the factor
  localparam int unsigned ST_LAST = ST_N3 + INV_W;     // factor quotient ready
  localparam int unsigned ST_OUT  = ST_LAST + 1;       // output register

  localparam logic [95:0] INV_SAT_CUBE = 96'd16777216; // r^3 at or below 2^24 saturates 1/r^3
  localparam logic [30:0] COS_ONE      = 31'h4000_0000;

  typedef struct packed {
    logic [31:0] dx;
    logic [31:0] dy;
    logic [31:0] dz;
    logic        az;
  } side_t;

  function automatic logic [4:0] msb_idx(logic [31:0] v);
    logic [4:0] p;
    p = '0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) begin
        p = 5'(i);
      end
    end
    return p;
  endfunction

endpackage

@@ design/dipolar_geometry_kernel.sv @@
// Dipolar geometry kernel. Each input beat carries a target point, a source point and an axis
// vector in signed Q16.16; each output beat carries the saturated displacement, the distance r,
// 1/r^3 (Q24.24), the cosine to the axis (Q2.30) and (3cos^2-1)/r^3 (Q24.24), plus the
// distance_valid and axis_zero flags. The block is a fully pipelined datapath of 155 register
// stages, the last of them being the output register: it takes one beat per clock while the input
// is not stalled, accepting a new beat before the earlier ones have left the pipe.
// That depth is set by the bit-per-stage square roots and restoring dividers (32 stages for the
// distance root, 22 for the norm roots, 42 plus 32 for the cosine divisions and 48 for the
// factor division, which follows the cosine). All stages advance together on one enable; the
// pipeline holds only while the output register is full and the consumer stalls, and in that
// same cycle the input is stalled. Gaps between beats travel through the pipe unchanged.
module dipolar_geometry_kernel (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] target_x_i,
  input  logic signed [31:0] target_y_i,
  input  logic signed [31:0] target_z_i,
  input  logic signed [31:0] source_x_i,
  input  logic signed [31:0] source_y_i,
  input  logic signed [31:0] source_z_i,
  input  logic signed [31:0] axis_x_i,
  input  logic signed [31:0] axis_y_i,
  input  logic signed [31:0] axis_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] disp_x_o,
  output logic signed [31:0] disp_y_o,
  output logic signed [31:0] disp_z_o,
  output logic        [31:0] distance_o,
  output logic        [47:0] inverse_cube_o,
  output logic signed [31:0] cosine_o,
  output logic signed [48:0] dipolar_factor_o,
  output logic               distance_valid_o,
  output logic               axis_zero_o
);
  import dgk_pkg::*;

  // Global advance: every stage moves when the output register can take a beat.
  logic              en;
  logic [ST_OUT:1]   vld_q;

  assign in_stall_o  = vld_q[ST_OUT] & out_stall_i;
  assign en          = ~in_stall_o;
  assign out_valid_o = vld_q[ST_OUT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[ST_OUT-1:1], in_valid_i};
    end
  end

  // Stage 1: saturated displacement and the axis.
  logic signed [31:0] tgt [3];
  logic signed [31:0] src [3];
  logic signed [31:0] axs [3];
  logic signed [32:0] diff [3];
  logic signed [31:0] d_d [3];
  logic signed [31:0] d_q [3];
  logic signed [31:0] a_q [3];
  side_t              side_d;
  side_t              side_q [ST_SUB:ST_LAST];

  assign tgt = '{target_x_i, target_y_i, target_z_i};
  assign src = '{source_x_i, source_y_i, source_z_i};
  assign axs = '{axis_x_i, axis_y_i, axis_z_i};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = {src[i][31], src[i]} - {tgt[i][31], tgt[i]};
      if (diff[i][32] != diff[i][31]) begin
        d_d[i] = diff[i][32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
        d_d[i] = diff[i][31:0];
      end
    end
    side_d.dx = d_d[0];
    side_d.dy = d_d[1];
    side_d.dz = d_d[2];
    side_d.az = (axis_x_i == '0) && (axis_y_i == '0) && (axis_z_i == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_q       <= d_d;
      a_q       <= axs;
      side_q[ST_SUB] <= side_d;
    end
  end

  for (genvar s = ST_SUB + 1; s <= ST_LAST; s++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (en) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  // Stage 2: squares of the displacement, magnitudes for normalizing.
  logic signed [63:0] dsq [3];
  logic        [62:0] sq_q [3];
  logic        [31:0] md_d [3];
  logic        [31:0] ma_d [3];
  logic        [31:0] md_q [3];
  logic        [31:0] ma_q [3];
  logic        [2:0]  sd_q;
  logic        [2:0]  sa_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dsq[i]  = d_q[i] * d_q[i];
      md_d[i] = d_q[i][31] ? (~d_q[i] + 32'd1) : d_q[i];
      ma_d[i] = a_q[i][31] ? (~a_q[i] + 32'd1) : a_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= dsq[i][62:0];
        sd_q[i] <= d_q[i][31];
        sa_q[i] <= a_q[i][31];
      end
      md_q <= md_d;
      ma_q <= ma_d;
    end
  end

  // Stage 3: sum of squares; the leading one of the OR of the magnitudes gives the shift.
  logic [63:0] ssum_q;
  logic [31:0] md3_q [3];
  logic [31:0] ma3_q [3];
  logic [2:0]  sd3_q;
  logic [2:0]  sa3_q;
  logic [4:0]  pd_q;
  logic [4:0]  pa_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ssum_q <= {1'b0, sq_q[0]} + {1'b0, sq_q[1]} + {1'b0, sq_q[2]};
      md3_q  <= md_q;
      ma3_q  <= ma_q;
      sd3_q  <= sd_q;
      sa3_q  <= sa_q;
      pd_q   <= msb_idx(md_q[0] | md_q[1] | md_q[2]);
      pa_q   <= msb_idx(ma_q[0] | ma_q[1] | ma_q[2]);
    end
  end

  // Distance square root, one root bit per stage; the root then rides to the output.
  logic [63:0] sr_rem_q  [ST_SUM+1:ST_D-1];
  logic [31:0] sr_root_q [ST_SUM+1:ST_LAST];

  for (genvar s = ST_SUM + 1; s <= ST_LAST; s++) begin : g_sr
    if (s <= ST_D) begin : g_step
      localparam int unsigned J = ST_D - s;
      logic [63:0] rem_p;
      logic [31:0] root_p;
      logic [64:0] trial;
      logic        ge;
      logic [31:0] root_d;
      if (s == ST_SUM + 1) begin : g_first
        assign rem_p  = ssum_q;
        assign root_p = '0;
      end else begin : g_next
        assign rem_p  = sr_rem_q[s-1];
        assign root_p = sr_root_q[s-1];
      end
      assign trial  = (65'(root_p) << (J + 1)) + (65'(1) << (2 * J));
      assign ge     = {1'b0, rem_p} >= trial;
      assign root_d = root_p | (32'(ge) << J);
      if (s < ST_D) begin : g_rem
        always_ff @(posedge clk_i) begin
          if (en) begin
            sr_rem_q[s] <= ge ? (rem_p - trial[63:0]) : rem_p;
          end
        end
      end
      always_ff @(posedge clk_i) begin
        if (en) begin
          sr_root_q[s] <= root_d;
        end
      end
    end else begin : g_copy
      always_ff @(posedge clk_i) begin
        if (en) begin
          sr_root_q[s] <= sr_root_q[s-1];
        end
      end
    end
  end

  // r^3 in three stages: r^2, two 32x32 partial products, then their sum.
  logic [63:0] d2_q;
  logic [63:0] pl_q;
  logic [63:0] ph_q;
  logic [95:0] c_q [ST_C:ST_LAST-1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      d2_q     <= 64'(sr_root_q[ST_D]) * 64'(sr_root_q[ST_D]);
      pl_q     <= 64'(d2_q[31:0]) * 64'(sr_root_q[ST_D2]);
      ph_q     <= 64'(d2_q[63:32]) * 64'(sr_root_q[ST_D2]);
      c_q[ST_C] <= {ph_q, 32'b0} + {32'b0, pl_q};
    end
  end

  for (genvar s = ST_C + 1; s <= ST_LAST - 1; s++) begin : g_cube
    always_ff @(posedge clk_i) begin
      if (en) begin
        c_q[s] <= c_q[s-1];
      end
    end
  end

  // 1/r^3: restoring division of 2^72 by r^3, one quotient bit per stage.
  logic [72:0] iv_rem_q [ST_C+1:ST_INV-1];
  logic [47:0] iv_quo_q [ST_C+1:ST_INV];
  logic [47:0] invc_q   [ST_INV+1:ST_LAST];

  for (genvar s = ST_C + 1; s <= ST_INV; s++) begin : g_iv
    localparam int unsigned K = ST_INV - s;
    logic [72:0]  rem_p;
    logic [47:0]  quo_p;
    logic [143:0] trial;
    logic         ge;
    if (s == ST_C + 1) begin : g_first
      assign rem_p = 73'(1) << 72;
      assign quo_p = '0;
    end else begin : g_next
      assign rem_p = iv_rem_q[s-1];
      assign quo_p = iv_quo_q[s-1];
    end
    assign trial = {48'b0, c_q[s-1]} << K;
    assign ge    = {71'b0, rem_p} >= trial;
    if (s < ST_INV) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en) begin
          iv_rem_q[s] <= ge ? (rem_p - trial[72:0]) : rem_p;
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        iv_quo_q[s] <= quo_p | (48'(ge) << K);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      invc_q[ST_INV+1] <= (c_q[ST_INV] <= INV_SAT_CUBE) ? '1 : iv_quo_q[ST_INV];
    end
  end

  for (genvar s = ST_INV + 2; s <= ST_LAST; s++) begin : g_invc
    always_ff @(posedge clk_i) begin
      if (en) begin
        invc_q[s] <= invc_q[s-1];
      end
    end
  end

  // Stage 4: both vectors scaled so their largest magnitude sits at bit 20.
  logic        [31:0] shu [3];
  logic        [31:0] shw [3];
  logic signed [21:0] u_q [3];
  logic signed [21:0] w_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      shu[i] = (pd_q >= 5'd20) ? (md3_q[i] >> (pd_q - 5'd20)) : (md3_q[i] << (5'd20 - pd_q));
      shw[i] = (pa_q >= 5'd20) ? (ma3_q[i] >> (pa_q - 5'd20)) : (ma3_q[i] << (5'd20 - pa_q));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        u_q[i] <= sd3_q[i] ? -$signed({1'b0, shu[i][20:0]}) : $signed({1'b0, shu[i][20:0]});
        w_q[i] <= sa3_q[i] ? -$signed({1'b0, shw[i][20:0]}) : $signed({1'b0, shw[i][20:0]});
      end
    end
  end

  // Stages 5 and 6: component products, then dot product and squared norms.
  logic signed [43:0] uw_q [3];
  logic signed [43:0] uu_q [3];
  logic signed [43:0] ww_q [3];
  logic signed [45:0] dot_q [ST_DOT:ST_NRT];
  logic        [43:0] nsq_q [2];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        uw_q[i] <= u_q[i] * w_q[i];
        uu_q[i] <= u_q[i] * u_q[i];
        ww_q[i] <= w_q[i] * w_q[i];
      end
      dot_q[ST_DOT] <= 46'(uw_q[0]) + 46'(uw_q[1]) + 46'(uw_q[2]);
      nsq_q[0]      <= uu_q[0] + uu_q[1] + uu_q[2];
      nsq_q[1]      <= ww_q[0] + ww_q[1] + ww_q[2];
    end
  end

  for (genvar s = ST_DOT + 1; s <= ST_NRT; s++) begin : g_dot
    always_ff @(posedge clk_i) begin
      if (en) begin
        dot_q[s] <= dot_q[s-1];
      end
    end
  end

  // Norm square roots: lane 0 is the displacement, lane 1 the axis.
  logic [43:0] nr_rem_q  [2][ST_DOT+1:ST_NRT-1];
  logic [21:0] nr_root_q [2][ST_DOT+1:ST_Q2-1];

  for (genvar l = 0; l < 2; l++) begin : g_lane
    for (genvar s = ST_DOT + 1; s <= ST_Q2 - 1; s++) begin : g_nr
      if (s <= ST_NRT) begin : g_step
        localparam int unsigned J = ST_NRT - s;
        logic [43:0] rem_p;
        logic [21:0] root_p;
        logic [45:0] trial;
        logic        ge;
        if (s == ST_DOT + 1) begin : g_first
          assign rem_p  = nsq_q[l];
          assign root_p = '0;
        end else begin : g_next
          assign rem_p  = nr_rem_q[l][s-1];
          assign root_p = nr_root_q[l][s-1];
        end
        assign trial = (46'(root_p) << (J + 1)) + (46'(1) << (2 * J));
        assign ge    = {2'b0, rem_p} >= trial;
        if (s < ST_NRT) begin : g_rem
          always_ff @(posedge clk_i) begin
            if (en) begin
              nr_rem_q[l][s] <= ge ? (rem_p - trial[43:0]) : rem_p;
            end
          end
        end
        always_ff @(posedge clk_i) begin
          if (en) begin
            nr_root_q[l][s] <= root_p | (22'(ge) << J);
          end
        end
      end else begin : g_copy
        always_ff @(posedge clk_i) begin
          if (en) begin
            nr_root_q[l][s] <= nr_root_q[l][s-1];
          end
        end
      end
    end
  end

  // First cosine division: |dot| * 2^19 / |u|.
  logic [44:0]    adot;
  logic [63:0]    c1_rem_q [ST_NRT+1:ST_Q1-1];
  logic [Q1_W-1:0] c1_quo_q [ST_NRT+1:ST_Q1];
  logic [ST_Q2:ST_NRT+1] neg_q;

  assign adot = dot_q[ST_NRT][45] ? 45'(-dot_q[ST_NRT]) : dot_q[ST_NRT][44:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      neg_q <= {neg_q[ST_Q2-1:ST_NRT+1], dot_q[ST_NRT][45]};
    end
  end

  for (genvar s = ST_NRT + 1; s <= ST_Q1; s++) begin : g_c1
    localparam int unsigned K = ST_Q1 - s;
    logic [63:0]     rem_p;
    logic [Q1_W-1:0] quo_p;
    logic [63:0]     trial;
    logic            ge;
    if (s == ST_NRT + 1) begin : g_first
      assign rem_p = 64'(adot) << 19;
      assign quo_p = '0;
    end else begin : g_next
      assign rem_p = c1_rem_q[s-1];
      assign quo_p = c1_quo_q[s-1];
    end
    assign trial = 64'(nr_root_q[0][s-1]) << K;
    assign ge    = rem_p >= trial;
    if (s < ST_Q1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en) begin
          c1_rem_q[s] <= ge ? (rem_p - trial) : rem_p;
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        c1_quo_q[s] <= quo_p | (Q1_W'(ge) << K);
      end
    end
  end

  // Second cosine division: first quotient * 2^11 / |w|.
  logic [52:0]     c2_rem_q [ST_Q1+1:ST_Q2-1];
  logic [Q2_W-1:0] c2_quo_q [ST_Q1+1:ST_Q2];

  for (genvar s = ST_Q1 + 1; s <= ST_Q2; s++) begin : g_c2
    localparam int unsigned K = ST_Q2 - s;
    logic [52:0]     rem_p;
    logic [Q2_W-1:0] quo_p;
    logic [63:0]     trial;
    logic            ge;
    if (s == ST_Q1 + 1) begin : g_first
      assign rem_p = {c1_quo_q[ST_Q1], 11'b0};
      assign quo_p = '0;
    end else begin : g_next
      assign rem_p = c2_rem_q[s-1];
      assign quo_p = c2_quo_q[s-1];
    end
    assign trial = 64'(nr_root_q[1][s-1]) << K;
    assign ge    = {11'b0, rem_p} >= trial;
    if (s < ST_Q2) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en) begin
          c2_rem_q[s] <= ge ? (rem_p - trial[52:0]) : rem_p;
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        c2_quo_q[s] <= quo_p | (Q2_W'(ge) << K);
      end
    end
  end

  // Cosine: clamp to one, apply the sign, and force zero for a zero axis or zero distance.
  logic        [30:0] cmag;
  logic signed [31:0] cos_d;
  logic signed [31:0] cos_q [ST_COS:ST_LAST];

  always_comb begin
    cmag = (c2_quo_q[ST_Q2] > 32'(COS_ONE)) ? COS_ONE : c2_quo_q[ST_Q2][30:0];
    if (side_q[ST_Q2].az || (sr_root_q[ST_Q2] == '0)) begin
      cos_d = '0;
    end else begin
      cos_d = neg_q[ST_Q2] ? -$signed({1'b0, cmag}) : $signed({1'b0, cmag});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cos_q[ST_COS] <= cos_d;
    end
  end

  for (genvar s = ST_COS + 1; s <= ST_LAST; s++) begin : g_cos
    always_ff @(posedge clk_i) begin
      if (en) begin
        cos_q[s] <= cos_q[s-1];
      end
    end
  end

  // Angular term T = 3*floor(c^2 / 2^30) - 2^30, then its magnitude and sign.
  logic [30:0] acos;
  logic [60:0] csq_q;
  logic [30:0] cfl;
  logic [33:0] t_d;
  logic [31:0] at_q [ST_T:ST_N3];
  logic [ST_LAST:ST_T] tneg_q;

  assign acos = cos_q[ST_COS][31] ? 31'(-cos_q[ST_COS]) : cos_q[ST_COS][30:0];
  assign cfl  = csq_q[60:30];
  assign t_d  = {3'b0, cfl} + {2'b0, cfl, 1'b0} - (34'(1) << 30);

  always_ff @(posedge clk_i) begin
    if (en) begin
      csq_q      <= 61'(acos) * 61'(acos);
      at_q[ST_T] <= t_d[33] ? 32'(~t_d + 34'd1) : t_d[31:0];
      at_q[ST_N3] <= at_q[ST_T];
      tneg_q     <= {tneg_q[ST_LAST-1:ST_T], t_d[33]};
    end
  end

  // Factor division: |T| * 2^42 / r^3, with the saturation case found up front.
  logic [ST_LAST:ST_N3] ovf_q;
  logic [73:0]          f_rem_q [ST_N3+1:ST_LAST-1];
  logic [47:0]          f_quo_q [ST_N3+1:ST_LAST];

  always_ff @(posedge clk_i) begin
    if (en) begin
      ovf_q <= {ovf_q[ST_LAST-1:ST_N3],
                {70'b0, at_q[ST_T], 42'b0} >= ({48'b0, c_q[ST_T]} << 48)};
    end
  end

  for (genvar s = ST_N3 + 1; s <= ST_LAST; s++) begin : g_f
    localparam int unsigned K = ST_LAST - s;
    logic [73:0]  rem_p;
    logic [47:0]  quo_p;
    logic [143:0] trial;
    logic         ge;
    if (s == ST_N3 + 1) begin : g_first
      assign rem_p = {at_q[ST_N3], 42'b0};
      assign quo_p = '0;
    end else begin : g_next
      assign rem_p = f_rem_q[s-1];
      assign quo_p = f_quo_q[s-1];
    end
    assign trial = {48'b0, c_q[s-1]} << K;
    assign ge    = {70'b0, rem_p} >= trial;
    if (s < ST_LAST) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en) begin
          f_rem_q[s] <= ge ? (rem_p - trial[73:0]) : rem_p;
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        f_quo_q[s] <= quo_p | (48'(ge) << K);
      end
    end
  end

  // Output register. A zero distance zeroes every derived field.
  logic        ok;
  logic [48:0] fmag;
  logic [48:0] dip_d;

  assign ok   = sr_root_q[ST_LAST] != '0;
  assign fmag = ovf_q[ST_LAST] ? (49'(1) << 48) : {1'b0, f_quo_q[ST_LAST]};

  always_comb begin
    if (!ok) begin
      dip_d = '0;
    end else if (tneg_q[ST_LAST]) begin
      dip_d = ~fmag + 49'd1;
    end else if (ovf_q[ST_LAST]) begin
      dip_d = {1'b0, {48{1'b1}}};
    end else begin
      dip_d = fmag;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      disp_x_o         <= side_q[ST_LAST].dx;
      disp_y_o         <= side_q[ST_LAST].dy;
      disp_z_o         <= side_q[ST_LAST].dz;
      axis_zero_o      <= side_q[ST_LAST].az;
      distance_o       <= sr_root_q[ST_LAST];
      distance_valid_o <= ok;
      inverse_cube_o   <= ok ? invc_q[ST_LAST] : '0;
      cosine_o         <= cos_q[ST_LAST];
      dipolar_factor_o <= dip_d;
    end
  end

endmodule
